// File: rtl/lts_pkg.sv
// Shared types, constants and fixed-point coefficients of the stereo tremolo.
`default_nettype none

package lts_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int DEF_PHASE_BITS      = 24;
   localparam int DEF_SINE_TABLE_BITS = 10;
   localparam int DEF_SAMPLE_BITS     = 24;

   // Shared multiplier operand width and the fixed-point scalings.
   localparam int MUL_BITS       = 32;
   localparam int SINE_FRAC      = 30;
   localparam int GAIN_FRAC      = 32;
   localparam int Q16_BITS       = 17;
   localparam int PHASE_INC_BITS = 20;

   // Configuration port sizes.
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 20;

   localparam logic [Q16_BITS-1:0] Q16_ONE      = 17'd65536;
   localparam logic [Q16_BITS-1:0] Q16_HALF     = 17'd32768;
   localparam logic [Q16_BITS-1:0] Q16_ROUND    = 17'd32768;
   localparam logic [15:0]         COEF_SQUARE  = 16'd65339;
   localparam logic [15:0]         COEF_OTHER   = 16'd58982;
   localparam logic [31:0]         SINE_ROUND   = 32'd16384;

   // Odd polynomial for the quarter-wave sine in Q30, evaluated by Horner steps.
   localparam logic [31:0] POLY_C0 = 32'd1686629713;
   localparam logic [31:0] POLY_C1 = 32'd693598669;
   localparam logic [31:0] POLY_C2 = 32'd85569306;
   localparam logic [31:0] POLY_C3 = 32'd5026995;
   localparam logic [31:0] POLY_C4 = 32'd172272;

   // Reset values of the configuration registers.
   localparam logic [PHASE_INC_BITS-1:0] RST_PHASE_INC = 20'd1573;
   localparam logic [Q16_BITS-1:0]       RST_DEPTH     = 17'd39322;
   localparam logic [Q16_BITS-1:0]       RST_MIX       = 17'd65536;

   typedef enum logic [1:0] {
      SHAPE_SINE     = 2'd0,
      SHAPE_TRIANGLE = 2'd1,
      SHAPE_SQUARE   = 2'd2,
      SHAPE_SINE_ALT = 2'd3
   } shape_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PHASE_INC = 4'd0,
      REG_DEPTH     = 4'd1,
      REG_SHAPE     = 4'd2,
      REG_MIX       = 4'd3
   } reg_index_type;

   typedef struct packed {
      logic [PHASE_INC_BITS-1:0] phase_inc;
      logic [Q16_BITS-1:0]       depth;
      shape_type                 shape;
      logic [Q16_BITS-1:0]       mix;
   } cfg_type;

   // Values the oscillator offers for the current phase.
   typedef struct packed {
      logic [SINE_FRAC:0]  x;
      logic                neg;
      logic [Q16_BITS-1:0] tri_u;
      logic [Q16_BITS-1:0] sq_u;
   } lfo_tap_type;

   typedef struct packed {
      logic [MUL_BITS-1:0] a;
      logic [MUL_BITS-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_status_type;

endpackage

`default_nettype wire

// File: rtl/lts_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none

module lts_mul (
   input  wire logic                        clock,
   input  wire lts_pkg::mul_req_type        req,
   output logic [2*lts_pkg::MUL_BITS-1:0]   prod
);
   import lts_pkg::*;

   logic [2*MUL_BITS-1:0] prod_ff;
   logic [2*MUL_BITS-1:0] prod_in;

   // One full-width product per cycle.
   assign prod_in = (2*MUL_BITS)'(req.a) * (2*MUL_BITS)'(req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// File: rtl/lts_lfo.sv
// Phase accumulator and waveform decode of the low-frequency oscillator.
`default_nettype none

module lts_lfo #(
   parameter int PHASE_BITS      = lts_pkg::DEF_PHASE_BITS,
   parameter int SINE_TABLE_BITS = lts_pkg::DEF_SINE_TABLE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic [lts_pkg::PHASE_INC_BITS-1:0]  phase_inc,
   output lts_pkg::lfo_tap_type                     tap
);
   import lts_pkg::*;

   localparam int SUM_W = (PHASE_BITS > PHASE_INC_BITS) ? PHASE_BITS : PHASE_INC_BITS;

   logic [PHASE_BITS-1:0]      phase_ff;
   logic [PHASE_BITS-1:0]      phase_in;
   logic [SUM_W-1:0]           phase_sum;
   logic [1:0]                 quad;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [SINE_TABLE_BITS:0]   k;
   logic [15:0]                p16;
   logic [Q16_BITS-1:0]        tri2;
   logic [Q16_BITS-1:0]        tri_dist;

   // The phase wraps modulo its own width.
   assign phase_sum = SUM_W'(phase_ff) + SUM_W'(phase_inc);
   assign phase_in  = advance ? phase_sum[PHASE_BITS-1:0] : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Quarter-wave index, mirrored in the odd quadrants.
   assign quad = phase_ff[PHASE_BITS-1 -: 2];
   assign idx  = phase_ff[PHASE_BITS-3 -: SINE_TABLE_BITS];
   assign k    = quad[0] ? ((SINE_TABLE_BITS+1)'(1) << SINE_TABLE_BITS) - {1'b0, idx}
                         : {1'b0, idx};

   // Triangle folds the top sixteen phase bits around the midpoint.
   assign p16      = phase_ff[PHASE_BITS-1 -: 16];
   assign tri2     = {p16, 1'b0};
   assign tri_dist = tri2[16] ? {1'b0, tri2[15:0]} : Q16_ONE - tri2;

   always_comb begin
      tap.x     = (SINE_FRAC+1)'(k) << (SINE_FRAC - SINE_TABLE_BITS);
      tap.neg   = quad[1];
      tap.tri_u = Q16_ONE - tri_dist;
      tap.sq_u  = phase_ff[PHASE_BITS-1] ? '0 : Q16_ONE;
   end

endmodule

`default_nettype wire

// File: rtl/lts_core.sv
// Sequencer that runs the sine polynomial, gain smoother and channel scaling on one multiplier.
`default_nettype none

module lts_core #(
   parameter int SAMPLE_BITS = lts_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              out_free,
   input  wire logic [SAMPLE_BITS-1:0]            left_in,
   input  wire logic [SAMPLE_BITS-1:0]            right_in,
   input  wire lts_pkg::cfg_type                  cfg,
   input  wire lts_pkg::lfo_tap_type              tap,
   input  wire logic [2*lts_pkg::MUL_BITS-1:0]    prod,
   output lts_pkg::mul_req_type                   mul_req,
   output lts_pkg::core_status_type               status,
   output logic [SAMPLE_BITS-1:0]                 left_res,
   output logic [SAMPLE_BITS-1:0]                 right_res
);
   import lts_pkg::*;

   localparam int ACC_W = SAMPLE_BITS + GAIN_FRAC + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_SQ, S_H4, S_H3, S_H2, S_H1, S_FX, S_SN, S_TG, S_SM1, S_SM2,
      S_SM3, S_MX, S_LH, S_LL, S_RH, S_RL, S_F1, S_F2, S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [SAMPLE_BITS-1:0]  left_ff, left_in_next;
   logic [SAMPLE_BITS-1:0]  right_ff, right_in_next;
   logic [31:0]             x2_ff, x2_in;
   logic [Q16_BITS-1:0]     u_ff, u_in;
   logic [Q16_BITS-1:0]     gain_ff, gain_in;
   logic [32:0]             m_ff, m_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [SAMPLE_BITS-1:0]  left_res_ff, left_res_in;
   logic [SAMPLE_BITS-1:0]  right_res_ff, right_res_in;

   logic [31:0]             prod_hi;
   logic [31:0]             sine_sum;
   logic [Q16_BITS-1:0]     sine_raw;
   logic [Q16_BITS-1:0]     sine_s;
   logic [Q16_BITS-1:0]     sine_u;
   logic [Q16_BITS-1:0]     depth_sat;
   logic [Q16_BITS-1:0]     mix_sat;
   logic [Q16_BITS-1:0]     gain_sat;
   logic [15:0]             coef;
   logic [32:0]             target_sum;
   logic [Q16_BITS-1:0]     target;
   logic [33:0]             smooth_sum;
   logic                    neg_l, neg_r;
   logic [SAMPLE_BITS-1:0]  mag_l, mag_r;

   // Takes the Q32 product off the magnitude, rounds back to a sample and restores the sign, with saturation.
   function automatic logic [SAMPLE_BITS-1:0] finish_sample(
      input logic [SAMPLE_BITS-1:0] mag,
      input logic                   neg,
      input logic [ACC_W-1:0]       scaled
   );
      logic [ACC_W-1:0]       full;
      logic [SAMPLE_BITS:0]   r;
      logic [SAMPLE_BITS:0]   half;
      logic [SAMPLE_BITS:0]   nr;
      begin
         full = (ACC_W'(mag) << GAIN_FRAC) - scaled + (ACC_W'(1) << (GAIN_FRAC - 1));
         r    = full[ACC_W-1:GAIN_FRAC];
         half = (SAMPLE_BITS+1)'(1) << (SAMPLE_BITS - 1);
         if (neg) begin
            if (r > half) begin
               r = half;
            end
            nr = ~r + (SAMPLE_BITS+1)'(1);
         end else begin
            if (r > half - (SAMPLE_BITS+1)'(1)) begin
               r = half - (SAMPLE_BITS+1)'(1);
            end
            nr = r;
         end
         finish_sample = nr[SAMPLE_BITS-1:0];
      end
   endfunction

   // Settings clamped to full scale, and the smoother coefficient for the shape.
   assign depth_sat = (cfg.depth > Q16_ONE) ? Q16_ONE : cfg.depth;
   assign mix_sat   = (cfg.mix > Q16_ONE) ? Q16_ONE : cfg.mix;
   assign gain_sat  = (gain_ff > Q16_ONE) ? Q16_ONE : gain_ff;
   assign coef      = (cfg.shape == SHAPE_SQUARE) ? COEF_SQUARE : COEF_OTHER;

   // Q30 view of the product and the finished sine value.
   assign prod_hi  = prod[2*SINE_FRAC+1:SINE_FRAC];
   assign sine_sum = prod_hi + SINE_ROUND;
   assign sine_raw = sine_sum[31:15];
   assign sine_s   = (sine_raw > Q16_HALF) ? Q16_HALF : sine_raw;
   assign sine_u   = tap.neg ? Q16_HALF - sine_s : Q16_HALF + sine_s;

   // Target gain from the depth product, and the two-term smoother sum.
   assign target_sum = prod[32:0] + 33'(Q16_ROUND);
   assign target     = Q16_ONE - target_sum[32:16];
   assign smooth_sum = acc_ff[33:0] + 34'(prod[32:0]) + 34'(Q16_ROUND);

   // Sample magnitudes.
   assign neg_l = left_ff[SAMPLE_BITS-1];
   assign neg_r = right_ff[SAMPLE_BITS-1];
   assign mag_l = neg_l ? (~left_ff + SAMPLE_BITS'(1)) : left_ff;
   assign mag_r = neg_r ? (~right_ff + SAMPLE_BITS'(1)) : right_ff;

   // Sequencer: each state issues at most one product; the next state may consume it.
   always_comb begin
      state_in      = state_ff;
      left_in_next  = left_ff;
      right_in_next = right_ff;
      x2_in         = x2_ff;
      u_in          = u_ff;
      gain_in       = gain_ff;
      m_in          = m_ff;
      acc_in        = acc_ff;
      left_res_in   = left_res_ff;
      right_res_in  = right_res_ff;
      mul_req.a     = '0;
      mul_req.b     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               left_in_next  = left_in;
               right_in_next = right_in;
               state_in      = S_SQ;
            end
         end
         S_SQ: begin
            mul_req.a = MUL_BITS'(tap.x);
            mul_req.b = MUL_BITS'(tap.x);
            state_in  = S_H4;
         end
         S_H4: begin
            x2_in     = prod_hi;
            mul_req.a = prod_hi;
            mul_req.b = POLY_C4;
            state_in  = S_H3;
         end
         S_H3: begin
            mul_req.a = x2_ff;
            mul_req.b = POLY_C3 - prod_hi;
            state_in  = S_H2;
         end
         S_H2: begin
            mul_req.a = x2_ff;
            mul_req.b = POLY_C2 - prod_hi;
            state_in  = S_H1;
         end
         S_H1: begin
            mul_req.a = x2_ff;
            mul_req.b = POLY_C1 - prod_hi;
            state_in  = S_FX;
         end
         S_FX: begin
            mul_req.a = MUL_BITS'(tap.x);
            mul_req.b = POLY_C0 - prod_hi;
            state_in  = S_SN;
         end
         S_SN: begin
            case (cfg.shape)
               SHAPE_TRIANGLE: u_in = tap.tri_u;
               SHAPE_SQUARE:   u_in = tap.sq_u;
               default:        u_in = sine_u;
            endcase
            state_in = S_TG;
         end
         S_TG: begin
            mul_req.a = MUL_BITS'(depth_sat);
            mul_req.b = MUL_BITS'(Q16_ONE - u_ff);
            state_in  = S_SM1;
         end
         S_SM1: begin
            mul_req.a = MUL_BITS'(Q16_ONE - Q16_BITS'(coef));
            mul_req.b = MUL_BITS'(target);
            state_in  = S_SM2;
         end
         S_SM2: begin
            acc_in    = ACC_W'(prod[32:0]);
            mul_req.a = MUL_BITS'(coef);
            mul_req.b = MUL_BITS'(gain_sat);
            state_in  = S_SM3;
         end
         S_SM3: begin
            gain_in  = smooth_sum[32:16];
            state_in = S_MX;
         end
         S_MX: begin
            mul_req.a = MUL_BITS'(mix_sat);
            mul_req.b = MUL_BITS'(Q16_ONE - gain_ff);
            state_in  = S_LH;
         end
         S_LH: begin
            m_in      = prod[32:0];
            mul_req.a = MUL_BITS'(mag_l);
            mul_req.b = MUL_BITS'(prod[32:16]);
            state_in  = S_LL;
         end
         S_LL: begin
            acc_in    = ACC_W'(prod);
            mul_req.a = MUL_BITS'(mag_l);
            mul_req.b = MUL_BITS'(m_ff[15:0]);
            state_in  = S_RH;
         end
         S_RH: begin
            acc_in    = (acc_ff << 16) + ACC_W'(prod);
            mul_req.a = MUL_BITS'(mag_r);
            mul_req.b = MUL_BITS'(m_ff[32:16]);
            state_in  = S_RL;
         end
         S_RL: begin
            left_res_in = finish_sample(mag_l, neg_l, acc_ff);
            acc_in      = ACC_W'(prod);
            mul_req.a   = MUL_BITS'(mag_r);
            mul_req.b   = MUL_BITS'(m_ff[15:0]);
            state_in    = S_F1;
         end
         S_F1: begin
            acc_in   = (acc_ff << 16) + ACC_W'(prod);
            state_in = S_F2;
         end
         S_F2: begin
            right_res_in = finish_sample(mag_r, neg_r, acc_ff);
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gain_ff  <= Q16_ONE;
      end else begin
         state_ff <= state_in;
         gain_ff  <= gain_in;
      end
      left_ff      <= left_in_next;
      right_ff     <= right_in_next;
      x2_ff        <= x2_in;
      u_ff         <= u_in;
      m_ff         <= m_in;
      acc_ff       <= acc_in;
      left_res_ff  <= left_res_in;
      right_res_ff <= right_res_in;
   end

   always_comb begin
      status.idle = (state_ff == S_IDLE);
      status.done = (state_ff == S_DONE) && out_free;
   end

   assign left_res  = left_res_ff;
   assign right_res = right_res_ff;

endmodule

`default_nettype wire

// File: rtl/lfo_tremolo_stereo.sv
// Stereo tremolo top level: configuration registers, handshakes and the output register.
// Each frame passes through the sine polynomial, the gain smoother and the channel scaling.
// A new frame is accepted only while the sequencer is idle, since the fourteen dependent products
// of each frame are computed one after another on the single shared 32 x 32 multiplier.
// A finished result waits in the output register while the next frame is accepted.
// Reset is synchronous: it restores the register defaults, zero phase and unity gain.
`default_nettype none

module lfo_tremolo_stereo #(
   parameter int PHASE_BITS      = lts_pkg::DEF_PHASE_BITS,
   parameter int SINE_TABLE_BITS = lts_pkg::DEF_SINE_TABLE_BITS,
   parameter int SAMPLE_BITS     = lts_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_left_in,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_right_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]            rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]            rsp_right_out,
   input  wire logic                                csr_write,
   input  wire logic [lts_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lts_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import lts_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic [SAMPLE_BITS-1:0] rsp_right_ff, rsp_right_in;

   lfo_tap_type            tap;
   mul_req_type            mul_req;
   logic [2*MUL_BITS-1:0]  prod;
   core_status_type        status;
   logic [SAMPLE_BITS-1:0] left_res;
   logic [SAMPLE_BITS-1:0] right_res;
   logic                   start;
   logic                   out_free;

   // Register writes; an index past the list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_PHASE_INC: cfg_in.phase_inc = csr_wdata[PHASE_INC_BITS-1:0];
            REG_DEPTH:     cfg_in.depth     = csr_wdata[Q16_BITS-1:0];
            REG_SHAPE:     cfg_in.shape     = shape_type'(csr_wdata[1:0]);
            REG_MIX:       cfg_in.mix       = csr_wdata[Q16_BITS-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // Input transfer starts the sequencer; the output register frees up on a result transfer.
   assign req_ready = status.idle;
   assign start     = req_valid && status.idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_left_in  = left_res;
         rsp_right_in = right_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_inc <= RST_PHASE_INC;
         cfg_ff.depth     <= RST_DEPTH;
         cfg_ff.shape     <= SHAPE_SINE;
         cfg_ff.mix       <= RST_MIX;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   lts_lfo #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_lfo (
      .clock     (clock),
      .reset     (reset),
      .advance   (status.done),
      .phase_inc (cfg_ff.phase_inc),
      .tap       (tap)
   );

   lts_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .prod  (prod)
   );

   lts_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .out_free  (out_free),
      .left_in   (req_left_in),
      .right_in  (req_right_in),
      .cfg       (cfg_ff),
      .tap       (tap),
      .prod      (prod),
      .mul_req   (mul_req),
      .status    (status),
      .left_res  (left_res),
      .right_res (right_res)
   );

   // A frame in progress blocks the next input transfer.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a frame was in progress");

   // A new result never lands on one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// File: tb/tb_lfo_tremolo_stereo.sv
// Self-checking testbench for the stereo tremolo with a built-in predictor of its frames.
`default_nettype none

module tb_lfo_tremolo_stereo;
   import lts_pkg::*;

   localparam int SW = DEF_SAMPLE_BITS;
   localparam int PW = DEF_PHASE_BITS;
   localparam int TW = DEF_SINE_TABLE_BITS;

   localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = '1;
   localparam logic [CSR_DATA_BITS-1:0] DATA_ALL_ONES = '1;
   localparam logic [CSR_DATA_BITS-1:0] Q16_OVER_MAX = 20'h1FFFF;

   localparam int NUM_PHASES     = 16;
   localparam int FRAMES_PER_PHASE = 100;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   // Block ports.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SW-1:0] req_left_in = '0;
   logic signed [SW-1:0] req_right_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SW-1:0] rsp_left_out;
   logic signed [SW-1:0] rsp_right_out;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // A typed-in expectation that travels along with the frame being offered.
   logic frame_fixed = 1'b0;
   logic signed [SW-1:0] fixed_left = '0;
   logic signed [SW-1:0] fixed_right = '0;

   typedef struct packed {
      logic signed [SW-1:0] left;
      logic signed [SW-1:0] right;
   } frame_type;

   typedef enum bit {ROW_FRAME, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] sel;
      logic [CSR_DATA_BITS-1:0]  data;
      logic signed [SW-1:0]      left;
      logic signed [SW-1:0]      right;
      bit                        fixed;
      logic signed [SW-1:0]      want_left;
      logic signed [SW-1:0]      want_right;
   } stim_row_type;

   // Predictor copy of the registers and the oscillator and smoother state.
   logic [PHASE_INC_BITS-1:0] cfg_step;
   logic [Q16_BITS-1:0]       cfg_depth;
   shape_type                 cfg_shape;
   logic [Q16_BITS-1:0]       cfg_mix;
   logic [PW-1:0]             osc_phase;
   logic [Q16_BITS-1:0]       gain_state;

   frame_type pending_frames[$];
   int     mismatch_count = 0;
   int     idle_cycles = 0;
   bit     burst_mode = 1'b0;
   bit     hold_output = 1'b0;

   lfo_tremolo_stereo dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_left_in(req_left_in),
      .req_right_in(req_right_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_left_out(rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Quarter-wave sine entry in Q15, from the Q30 odd polynomial with truncating products.
   function automatic logic [Q16_BITS-1:0] quarter_wave(input logic [63:0] k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      x  = k << (SINE_FRAC - TW);
      x2 = (x * x) >> SINE_FRAC;
      p  = 64'(POLY_C4);
      p  = 64'(POLY_C3) - ((x2 * p) >> SINE_FRAC);
      p  = 64'(POLY_C2) - ((x2 * p) >> SINE_FRAC);
      p  = 64'(POLY_C1) - ((x2 * p) >> SINE_FRAC);
      p  = 64'(POLY_C0) - ((x2 * p) >> SINE_FRAC);
      p  = (x * p) >> SINE_FRAC;
      p  = (p + 64'(SINE_ROUND)) >> 15;
      return (p > 64'(Q16_HALF)) ? Q16_HALF : p[Q16_BITS-1:0];
   endfunction

   // Unipolar oscillator level in Q1.16 for the given phase and shape.
   function automatic logic [63:0] lfo_level(input logic [PW-1:0] ph, input shape_type shape);
      logic [63:0] twice;
      logic [63:0] fold;
      logic [1:0]  quad;
      logic [63:0] idx;
      logic [63:0] s;
      case (shape)
         SHAPE_TRIANGLE: begin
            twice = (64'(ph) >> (PW - 16)) * 2;
            fold  = (twice >= 64'(Q16_ONE)) ? twice - 64'(Q16_ONE) : 64'(Q16_ONE) - twice;
            return 64'(Q16_ONE) - fold;
         end
         SHAPE_SQUARE: begin
            return ph[PW-1] ? 64'd0 : 64'(Q16_ONE);
         end
         default: begin
            quad = ph[PW-1 -: 2];
            idx  = (64'(ph) >> (PW - 2 - TW)) & ((64'd1 << TW) - 1);
            s    = quad[0] ? 64'(quarter_wave((64'd1 << TW) - idx)) : 64'(quarter_wave(idx));
            return quad[1] ? 64'(Q16_HALF) - s : 64'(Q16_HALF) + s;
         end
      endcase
   endfunction

   // Scales one sample by a Q32 gain, rounding half away from zero, then saturates.
   function automatic logic signed [SW-1:0] scale_sample(input logic signed [SW-1:0] raw,
                                                        input logic [63:0] gain32);
      logic [63:0] half;
      logic [63:0] mag;
      logic [63:0] r;
      half = 64'd1 << (SW - 1);
      mag  = raw[SW-1] ? (64'd1 << SW) - 64'({1'b0, raw}) : 64'({1'b0, raw});
      r    = (mag * gain32 + 64'h8000_0000) >> 32;
      if (raw[SW-1]) begin
         if (r > half) r = half;
         return SW'(~r + 64'd1);
      end
      if (r > half - 1) r = half - 1;
      return SW'(r);
   endfunction

   // Advances the oscillator and the gain smoother by one frame and forms both outputs.
   function automatic frame_type compute_tremolo(input frame_type dry);
      logic [63:0] depth;
      logic [63:0] mix;
      logic [63:0] level;
      logic [63:0] target;
      logic [63:0] coef;
      logic [63:0] g;
      logic [63:0] gain32;
      frame_type   wet;
      depth  = (cfg_depth > Q16_ONE) ? 64'(Q16_ONE) : 64'(cfg_depth);
      mix    = (cfg_mix > Q16_ONE) ? 64'(Q16_ONE) : 64'(cfg_mix);
      level  = lfo_level(osc_phase, cfg_shape);
      target = 64'(Q16_ONE) - ((depth * (64'(Q16_ONE) - level) + 64'(Q16_ROUND)) >> 16);
      coef   = (cfg_shape == SHAPE_SQUARE) ? 64'(COEF_SQUARE) : 64'(COEF_OTHER);
      g      = (gain_state > Q16_ONE) ? 64'(Q16_ONE) : 64'(gain_state);
      g      = (coef * g + (64'(Q16_ONE) - coef) * target + 64'(Q16_ROUND)) >> 16;
      gain_state = g[Q16_BITS-1:0];
      osc_phase  = osc_phase + PW'(cfg_step);
      gain32    = (64'd1 << GAIN_FRAC) - mix * (64'(Q16_ONE) - g);
      wet.left  = scale_sample(dry.left, gain32);
      wet.right = scale_sample(dry.right, gain32);
      return wet;
   endfunction

   // Predictor, scoreboard and watchdog, all sampled at the rising edge.
   always @(posedge clock) begin
      frame_type dry;
      frame_type want;
      if (reset) begin
         cfg_step   = RST_PHASE_INC;
         cfg_depth  = RST_DEPTH;
         cfg_shape  = SHAPE_SINE;
         cfg_mix    = RST_MIX;
         osc_phase  = '0;
         gain_state = Q16_ONE;
         pending_frames.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_PHASE_INC: cfg_step = csr_wdata[PHASE_INC_BITS-1:0];
               REG_DEPTH:     cfg_depth = csr_wdata[Q16_BITS-1:0];
               REG_SHAPE:     cfg_shape = shape_type'(csr_wdata[1:0]);
               REG_MIX:       cfg_mix = csr_wdata[Q16_BITS-1:0];
               default:       ;
            endcase
         end
         if (req_valid && req_ready) begin
            dry.left  = req_left_in;
            dry.right = req_right_in;
            want = compute_tremolo(dry);
            if (frame_fixed) begin
               want.left  = fixed_left;
               want.right = fixed_right;
            end
            pending_frames = {pending_frames, want};
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_frames.size() == 0) begin
               $error("rsp: result transfer with no frame outstanding");
               mismatch_count++;
            end else begin
               want = pending_frames.pop_front();
               if (rsp_left_out !== want.left) begin
                  $error("left_out: expected %0d, got %0d", want.left, rsp_left_out);
                  mismatch_count++;
               end
               if (rsp_right_out !== want.right) begin
                  $error("right_out: expected %0d, got %0d", want.right, rsp_right_out);
                  mismatch_count++;
               end
            end
         end
         // A hung handshake ends the run.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Result side: random stalls, calm stretches, and one long hold on request.
   initial begin
      int pick;
      @(negedge reset);
      forever begin
         @(posedge clock);
         pick = $urandom_range(0, 99);
         if (hold_output) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_output = 1'b0;
         end else if (pick < 40) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(0, 29)) @(posedge clock);
         end else if (pick < 55) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(50, 150)) @(posedge clock);
         end else if (pick < 92) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end
      end
   end

   // Gap before the next frame: mostly none, sometimes short, now and then long.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (burst_mode || pick < 70) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // Offers one frame and waits for its transfer; valid stays high for a back-to-back frame.
   task automatic send_frame(input logic signed [SW-1:0] left, input logic signed [SW-1:0] right,
                             input bit fixed, input logic signed [SW-1:0] want_left,
                             input logic signed [SW-1:0] want_right);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_left_in  <= left;
      req_right_in <= right;
      frame_fixed  <= fixed;
      fixed_left   <= want_left;
      fixed_right  <= want_right;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted frame has come back.
   // The first edge lets a transfer taken at the current edge reach the queue.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
   endtask

   // One register write, with csr_write low on either side of it.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] sel,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Q1.16 setting for depth or mix: off, full scale, over full scale, anywhere between, or any 20-bit value.
   function automatic logic [CSR_DATA_BITS-1:0] pick_q16();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return CSR_DATA_BITS'(Q16_ONE);
         2:       return CSR_DATA_BITS'($urandom_range(Q16_ONE + 1, Q16_OVER_MAX));
         3:       return CSR_DATA_BITS'($urandom());
         default: return CSR_DATA_BITS'($urandom_range(0, Q16_ONE));
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_step();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return DATA_ALL_ONES;
         2:       return CSR_DATA_BITS'($urandom());
         default: return CSR_DATA_BITS'($urandom_range(1, 4000));
      endcase
   endfunction

   function automatic logic signed [SW-1:0] pick_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) return SAMPLE_MAX;
      if (pick < 8) return SAMPLE_MIN;
      if (pick < 10) return SW'($urandom_range(0, 2)) - SW'(1);
      if (pick < 20) return SW'($urandom_range(0, 512)) - SW'(256);
      return SW'($urandom());
   endfunction

   // Directed rows: extremes, every shape, out-of-range settings and an ignored index.
   stim_row_type directed_rows [36] = '{
      '{ROW_FRAME, '0, '0, 0, 0, 1'b1, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, -1, 1, 1'b0, 0, 0},
      '{ROW_WRITE, REG_MIX, '0, 0, 0, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b1, SAMPLE_MAX, SAMPLE_MIN},
      '{ROW_FRAME, '0, '0, SAMPLE_MIN, SAMPLE_MAX, 1'b1, SAMPLE_MIN, SAMPLE_MAX},
      '{ROW_FRAME, '0, '0, 1, -1, 1'b1, 1, -1},
      '{ROW_FRAME, '0, '0, 24'sh555555, 24'shAAAAAA, 1'b1, 24'sh555555, 24'shAAAAAA},
      '{ROW_WRITE, REG_MIX, CSR_DATA_BITS'(Q16_ONE), 0, 0, 1'b0, 0, 0},
      '{ROW_WRITE, REG_DEPTH, Q16_OVER_MAX, 0, 0, 1'b0, 0, 0},
      '{ROW_WRITE, REG_SHAPE, CSR_DATA_BITS'(SHAPE_SQUARE), 0, 0, 1'b0, 0, 0},
      '{ROW_WRITE, REG_PHASE_INC, DATA_ALL_ONES, 0, 0, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, 1000, -1000, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, -1, -1, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, 123456, -654321, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, 1, 1, 1'b0, 0, 0},
      '{ROW_WRITE, REG_SHAPE, CSR_DATA_BITS'(SHAPE_TRIANGLE), 0, 0, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, -4000000, 4000000, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MIN, 1, 1'b0, 0, 0},
      '{ROW_WRITE, REG_SHAPE, CSR_DATA_BITS'(SHAPE_SINE_ALT), 0, 0, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, 2000000, -2000000, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 0, 0},
      '{ROW_WRITE, REG_UNUSED, DATA_ALL_ONES, 0, 0, 1'b0, 0, 0},
      '{ROW_WRITE, REG_DEPTH, '0, 0, 0, 1'b0, 0, 0},
      '{ROW_WRITE, REG_PHASE_INC, '0, 0, 0, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 0, 0},
      '{ROW_WRITE, REG_MIX, Q16_OVER_MAX, 0, 0, 1'b0, 0, 0},
      '{ROW_WRITE, REG_SHAPE, CSR_DATA_BITS'(SHAPE_SINE), 0, 0, 1'b0, 0, 0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 0, 0}
   };

   // Main sequence: reset, directed rows, random phases, then drain and report.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_drained();
            write_reg(directed_rows[i].sel, directed_rows[i].data);
         end else begin
            send_frame(directed_rows[i].left, directed_rows[i].right, directed_rows[i].fixed,
                       directed_rows[i].want_left, directed_rows[i].want_right);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         write_reg(REG_PHASE_INC, pick_step());
         write_reg(REG_DEPTH, pick_q16());
         write_reg(REG_SHAPE, CSR_DATA_BITS'($urandom_range(SHAPE_SINE, SHAPE_SINE_ALT)));
         write_reg(REG_MIX, pick_q16());
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_INDEX_BITS'($urandom_range(REG_MIX + 1, REG_UNUSED)),
                      CSR_DATA_BITS'($urandom()));
         burst_mode = (phase == 1) || ($urandom_range(0, 3) == 0);
         // Hold the result side long enough that the block backs up into its input.
         if (phase == 1) hold_output = 1'b1;
         for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
            // Once, let the pipeline empty completely in the middle of a phase.
            if (phase == 2 && n == FRAMES_PER_PHASE / 2) wait_drained();
            send_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
